>>> hdl/lse_pkg.sv
// Shared constants and the arctangent table function for the loop surface evaluator.
// No dependencies; used by lse_cordic and loop_surface_eval_core.
package lse_pkg;

    localparam int ZW = 33;  // turn-scaled angle, one bit of headroom
    localparam int XW = 34;  // CORDIC datapath width (Q30 plus growth)
    localparam int OUT_W = 18;
    localparam int ATAN_LEN = 24;

    localparam logic signed [XW-1:0] CORDIC_INIT = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] r;
        begin
            case (idx)
                0: r = 33'sd536870912;
                1: r = 33'sd316933406;
                2: r = 33'sd167458907;
                3: r = 33'sd85004756;
                4: r = 33'sd42667331;
                5: r = 33'sd21354465;
                6: r = 33'sd10679838;
                7: r = 33'sd5340245;
                8: r = 33'sd2670163;
                9: r = 33'sd1335087;
                10: r = 33'sd667544;
                11: r = 33'sd333772;
                12: r = 33'sd166886;
                13: r = 33'sd83443;
                14: r = 33'sd41722;
                15: r = 33'sd20861;
                16: r = 33'sd10430;
                17: r = 33'sd5215;
                18: r = 33'sd2608;
                19: r = 33'sd1304;
                20: r = 33'sd652;
                21: r = 33'sd326;
                22: r = 33'sd163;
                default: r = 33'sd81;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hdl/lse_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage, sin and cos of u and v.
// Depends on lse_pkg.
module lse_cordic #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ANGLE_BITS-1:0]       u_angle,
    input  logic [ANGLE_BITS-1:0]       v_angle,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] sin_u,
    output logic signed [FRAC_BITS+1:0] cos_u,
    output logic signed [FRAC_BITS+1:0] sin_v,
    output logic signed [FRAC_BITS+1:0] cos_v
);
    localparam int XW = lse_pkg::XW;
    localparam int ZW = lse_pkg::ZW;
    localparam int NS = (CORDIC_STEPS < lse_pkg::ATAN_LEN) ? CORDIC_STEPS : lse_pkg::ATAN_LEN;
    localparam int SH = 30 - FRAC_BITS;
    localparam int TW = FRAC_BITS + 2;

    // index 0: u, index 1: v
    logic signed [XW-1:0] x_reg [0:NS][0:1];
    logic signed [XW-1:0] y_reg [0:NS][0:1];
    logic signed [ZW-1:0] z_reg [0:NS][0:1];
    logic                 f_reg [0:NS][0:1];
    logic [NS:0]          vld_reg;

    logic [31:0] a_w [0:1];
    logic [31:0] ar_w [0:1];
    logic        fl_w [0:1];

    always_comb begin
        a_w[0] = {u_angle, {(32 - ANGLE_BITS){1'b0}}};
        a_w[1] = {v_angle, {(32 - ANGLE_BITS){1'b0}}};
        for (int k = 0; k < 2; k++) begin
            fl_w[k] = a_w[k][31] ^ a_w[k][30];
            ar_w[k] = fl_w[k] ? (a_w[k] + 32'h8000_0000) : a_w[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                x_reg[0][k] <= lse_pkg::CORDIC_INIT;
                y_reg[0][k] <= '0;
                z_reg[0][k] <= ZW'(signed'(ar_w[k]));
                f_reg[0][k] <= fl_w[k];
            end
            for (int i = 0; i < NS; i++) begin
                for (int k = 0; k < 2; k++) begin
                    if (!z_reg[i][k][ZW-1]) begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - lse_pkg::atan_turn(i);
                    end else begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + lse_pkg::atan_turn(i);
                    end
                    f_reg[i+1][k] <= f_reg[i][k];
                end
            end
        end
    end

    logic signed [XW-1:0] xs_w [0:1];
    logic signed [XW-1:0] ys_w [0:1];
    logic signed [XW-1:0] xr_w [0:1];
    logic signed [XW-1:0] yr_w [0:1];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            xs_w[k] = f_reg[NS][k] ? -x_reg[NS][k] : x_reg[NS][k];
            ys_w[k] = f_reg[NS][k] ? -y_reg[NS][k] : y_reg[NS][k];
            xr_w[k] = (xs_w[k] + (XW'(1) <<< (SH - 1))) >>> SH;
            yr_w[k] = (ys_w[k] + (XW'(1) <<< (SH - 1))) >>> SH;
        end
    end

    assign out_valid = vld_reg[NS];
    assign cos_u = xr_w[0][TW-1:0];
    assign sin_u = yr_w[0][TW-1:0];
    assign cos_v = xr_w[1][TW-1:0];
    assign sin_v = yr_w[1][TW-1:0];
endmodule

>>> hdl/loop_surface_eval_core.sv
// Loop surface evaluator top level: CORDIC pipeline, product stages, output register.
// Depends on lse_pkg and lse_cordic.
//
// channel | dir | fields
// s_axis  | in  | tdata = u_angle, v_angle
// m_axis  | out | tdata = point_x .. duv_x, 18 bits each
//
// Throughput one beat per cycle while the output is not stalled.
// Depth is set by the CORDIC input register and iteration stages, three product stages and the output register.
// Reset (aresetn low, synchronous) clears all valid bits.
// The whole pipeline advances when the output register is empty or taken.
module loop_surface_eval_core #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [AB-1:0] u_angle, [2AB-1:AB] v_angle, zero pad to bytes
    input  logic [((2*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // 18 bits each from low: point_x point_y point_z du_x dv_x dv_y dv_z
    // normal_y normal_z duu_x duv_x, zero pad
    output logic [199:0]                m_axis_tdata
);
    localparam int TW = FRAC_BITS + 2;
    localparam int PW = 2 * TW;
    localparam int OW = lse_pkg::OUT_W;
    localparam int EW = PW + 4;
    localparam logic signed [EW-1:0] OMAX = EW'(131071);
    localparam logic signed [EW-1:0] OMIN = -EW'(131072);

    logic en;
    logic out_valid_reg;
    logic cv;
    logic signed [TW-1:0] su, cu, sv, cvv;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    lse_cordic #(
        .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_axis_tvalid),
        .u_angle(s_axis_tdata[ANGLE_BITS-1:0]),
        .v_angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .out_valid(cv), .sin_u(su), .cos_u(cu), .sin_v(sv), .cos_v(cvv)
    );

    function automatic logic signed [EW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [EW-1:0] t;
        begin
            t = EW'(p) + (EW'(1) <<< (FRAC_BITS - 1));
            return t >>> FRAC_BITS;
        end
    endfunction

    function automatic logic [OW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        begin
            r = (v > OMAX) ? OMAX : ((v < OMIN) ? OMIN : v);
            return r[OW-1:0];
        end
    endfunction

    // stage A: first products
    logic                 a_vld_reg;
    logic signed [EW-1:0] sc_reg, cc_reg, ss_reg, cvv_reg, svv_reg, suv_reg, cuv_reg, csu_reg;
    logic signed [TW-1:0] a_su_reg, a_sv_reg, a_cv_reg;
    // stage B: second products
    logic                 b_vld_reg;
    logic signed [EW-1:0] b_sc_reg, b_cc_reg, b_ss_reg, b_svv_reg, b_cvs_reg, b_csu_reg;
    logic signed [EW-1:0] b_c2v_reg, b_n1_reg, b_nz_reg;
    logic signed [TW-1:0] b_sv_reg, b_cv_reg;
    // stage C: last product
    logic                 c_vld_reg;
    logic [199:0]         c_data_next, out_data_reg;
    logic signed [EW-1:0] c_ny_reg;
    logic signed [EW-1:0] c_sc_reg, c_cc_reg, c_ss_reg, c_cvs_reg, c_csu_reg, c_c2v_reg, c_nz_reg;
    logic signed [TW-1:0] c_sv_reg, c_cv_reg;

    logic signed [EW-1:0] c2v_w;
    assign c2v_w = 2 * cvv_reg - (EW'(1) <<< FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0; b_vld_reg <= 1'b0; c_vld_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= cv; b_vld_reg <= a_vld_reg; c_vld_reg <= b_vld_reg;
            out_valid_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg  <= rnd(sv * cu);
            cc_reg  <= rnd(cu * cvv);
            ss_reg  <= rnd(su * sv);
            cvv_reg <= rnd(cvv * cvv);
            svv_reg <= rnd(sv * sv);
            suv_reg <= rnd(sv * cvv);
            cuv_reg <= rnd(cu * sv);
            csu_reg <= rnd(cvv * su);
            a_su_reg <= su; a_sv_reg <= sv; a_cv_reg <= cvv;

            b_sc_reg <= sc_reg; b_cc_reg <= cc_reg; b_ss_reg <= ss_reg;
            b_svv_reg <= suv_reg; b_cvs_reg <= cuv_reg; b_csu_reg <= csu_reg;
            b_c2v_reg <= c2v_w;
            b_n1_reg <= ss_reg;
            b_nz_reg <= rnd(PW'(a_su_reg * $signed(svv_reg[TW-1:0])));
            b_sv_reg <= a_sv_reg; b_cv_reg <= a_cv_reg;

            c_ny_reg <= rnd(PW'($signed(b_n1_reg[TW-1:0]) * $signed(b_c2v_reg[TW-1:0])));
            c_sc_reg <= b_sc_reg; c_cc_reg <= b_cc_reg; c_ss_reg <= b_ss_reg;
            c_cvs_reg <= b_cvs_reg; c_csu_reg <= b_csu_reg; c_c2v_reg <= b_c2v_reg;
            c_nz_reg <= b_nz_reg; c_sv_reg <= b_sv_reg; c_cv_reg <= b_cv_reg;
            // point_z needs sv*cv; carried from stage A as b_svv_reg
            out_data_reg <= c_data_next;
        end
    end

    logic signed [EW-1:0] pz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pz_reg <= b_svv_reg;
        end
    end

    always_comb begin
        c_data_next = '0;
        c_data_next[0*OW +: OW]  = sat(c_sc_reg);
        c_data_next[1*OW +: OW]  = sat(2 * EW'(c_cv_reg));
        c_data_next[2*OW +: OW]  = sat(4 * pz_reg);
        c_data_next[3*OW +: OW]  = sat(-c_ss_reg);
        c_data_next[4*OW +: OW]  = sat(c_cc_reg);
        c_data_next[5*OW +: OW]  = sat(-2 * EW'(c_sv_reg));
        c_data_next[6*OW +: OW]  = sat(4 * c_c2v_reg);
        c_data_next[7*OW +: OW]  = sat(2 * c_ny_reg);
        c_data_next[8*OW +: OW]  = sat(c_nz_reg);
        c_data_next[9*OW +: OW]  = sat(-c_cvs_reg);
        c_data_next[10*OW +: OW] = sat(-c_csu_reg);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg && en |=> out_valid_reg)
        else $error("result lost at output stage");
endmodule

>>> dv/loop_surface_eval_core_tb.sv
// Testbench for loop_surface_eval_core: drives (u, v) angle beats and checks every
// surface term against a bit-exact CORDIC and fixed-point predictor. Uses lse_pkg.
`timescale 1ns / 100ps

module loop_surface_eval_core_tb;
    localparam int OUT_W = lse_pkg::OUT_W;

    localparam int AB = 16;
    localparam int FB = 14;
    localparam int STEPS = 16;
    localparam int NTERM = 11;
    localparam int LATENCY = STEPS + 4;

    typedef logic [NTERM*OUT_W-1:0] terms_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [199:0] m_axis_tdata;

    loop_surface_eval_core #(.ANGLE_BITS(AB), .FRAC_BITS(FB), .CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    terms_t expected_terms[$];
    int mismatches = 0;
    int stall_pct = 0;       // receiver idle percentage
    int gap_pct = 0;         // sender idle percentage
    int hold_off = 0;        // cycles for the receiver to hold off completely

    initial forever #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("FAIL loop_surface_eval_core");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_sh(a * b, FB);
    endfunction

    function automatic void angle_sincos(input logic [AB-1:0] ang, output longint s,
                                         output longint c);
        logic [31:0] a;
        logic flip;
        longint x, y, z, nx, ny;
        a = {ang, {(32-AB){1'b0}}};
        flip = 1'b0;
        x = lse_pkg::CORDIC_INIT;
        y = 0;
        // fold the two outer quarters onto the inner half turn
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                ny = y + floor_sh(x, i);
                z -= longint'(lse_pkg::atan_turn(i));
            end else begin
                nx = x + floor_sh(y, i);
                ny = y - floor_sh(x, i);
                z += longint'(lse_pkg::atan_turn(i));
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_sh(x, 30 - FB);
        s = round_sh(y, 30 - FB);
    endfunction

    function automatic logic [OUT_W-1:0] clamp18(longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[OUT_W-1:0];
    endfunction

    function automatic terms_t surface_terms(logic [AB-1:0] u, logic [AB-1:0] v);
        longint su, cu, sv, cv, c2v;
        longint t[NTERM];
        terms_t r;
        angle_sincos(u, su, cu);
        angle_sincos(v, sv, cv);
        c2v = 2 * qmul(cv, cv) - (longint'(1) << FB);
        t[0] = qmul(sv, cu);
        t[1] = 2 * cv;
        t[2] = 4 * qmul(sv, cv);
        t[3] = -qmul(su, sv);
        t[4] = qmul(cu, cv);
        t[5] = -2 * sv;
        t[6] = 4 * c2v;
        t[7] = 2 * qmul(qmul(su, sv), c2v);
        t[8] = qmul(su, qmul(sv, sv));
        t[9] = -qmul(cu, sv);
        t[10] = -qmul(cv, su);
        for (int k = 0; k < NTERM; k++) r[k*OUT_W +: OUT_W] = clamp18(t[k]);
        return r;
    endfunction

    // ---------------- result checker ----------------
    initial begin : check_results
        terms_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (expected_terms.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: %h", m_axis_tdata[NTERM*OUT_W-1:0]);
                end else begin
                    want = expected_terms.pop_front();
                    for (int k = 0; k < NTERM; k++) begin
                        if (m_axis_tdata[k*OUT_W +: OUT_W] !== want[k*OUT_W +: OUT_W]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("term %0d mismatch: expected %h, got %h", k,
                                         want[k*OUT_W +: OUT_W], m_axis_tdata[k*OUT_W +: OUT_W]);
                        end
                    end
                    if (m_axis_tdata[199:NTERM*OUT_W] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pad bits nonzero: %h", m_axis_tdata[199:NTERM*OUT_W]);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a full hold-off on request
    initial begin : drive_ready
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end else begin
                m_axis_tready <= aresetn && ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ---------------- stimulus ----------------
    // leaves tvalid high after the beat; a gap in the next call or wait_drained drops it
    task automatic send_angles(input logic [AB-1:0] u, input logic [AB-1:0] v);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, u};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_terms.push_back(surface_terms(u, v));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_terms.size() != 0) @(negedge aclk);
    endtask

    task automatic test_corner_angles();
        logic [AB-1:0] corners[10] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF,
                                       16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'hFFFF};
        for (int i = 0; i < 10; i++) send_angles(corners[i], corners[9 - i]);
        send_angles(16'h2000, 16'h2000);
        send_angles(16'hE000, 16'h6000);
        send_angles(16'hAAAA, 16'h5555);
        send_angles(16'h5555, 16'hAAAA);
    endtask

    task automatic test_random_angles(input int count);
        for (int i = 0; i < count; i++) send_angles(AB'($urandom()), AB'($urandom()));
    endtask

    task automatic test_backpressure();
        // block the output long enough that the pipeline fills and stalls its input
        hold_off = 3 * LATENCY;
        test_random_angles(3 * LATENCY);
        wait_drained();
    endtask

    task automatic test_quarter_turn_edges();
        logic [AB-1:0] base;
        for (int i = 0; i < 40; i++) begin
            base = AB'(16'h4000 * $urandom_range(3));
            send_angles(AB'(base + $urandom_range(8) - 4), AB'(base + $urandom_range(8) - 4));
        end
    endtask

    initial begin : run_tests
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_angles();
        wait_drained();
        stall_pct = 30;
        gap_pct = 30;
        test_random_angles(250);
        test_quarter_turn_edges();
        test_backpressure();
        // long stretch with both sides flowing freely
        stall_pct = 0;
        gap_pct = 0;
        test_random_angles(150);
        stall_pct = 30;
        gap_pct = 30;
        test_random_angles(150);
        wait_drained();
        repeat (LATENCY + 5) @(negedge aclk);
        if (mismatches == 0 && expected_terms.size() == 0) begin
            $display("PASS loop_surface_eval_core");
        end else begin
            $display("FAIL loop_surface_eval_core");
        end
        $finish;
    end
endmodule

>>> loop_surface_eval_core.f
hdl/lse_pkg.sv
hdl/lse_cordic.sv
hdl/loop_surface_eval_core.sv
dv/loop_surface_eval_core_tb.sv
